>>> rtl/rwmf_pkg.sv
// Package for the RGBA window median filter.
// Holds the transfer payload types, the register indexes and the controller interface.
// Depends on nothing.
package rwmf_pkg;

  localparam int unsigned RadiusWidth = 3;
  localparam int unsigned FwWidth = 11;
  localparam int unsigned FhWidth = 13;
  localparam int unsigned RowWidth = 13;
  localparam int unsigned HeightLimit = 4096;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 13;
  localparam int unsigned NumChan = 4;

  localparam logic [CfgIdxWidth-1:0] RegWindowRadius = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegFrameWidth = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegFrameHeight = 2'd2;

  localparam logic FuncPush = 1'b0;
  localparam logic FuncDrain = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
  } in_t;

  typedef struct packed {
    logic [7:0] med0;
    logic [7:0] med1;
    logic [7:0] med2;
    logic [7:0] med3;
    logic       frame_end;
  } out_t;

  typedef struct packed {
    logic push;
    logic setup;
    logic scan;
    logic resolve;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic win_ready;
    logic scan_last;
    logic bit_zero;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/rwmf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rwmf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/rwmf_ctrl.sv
// Controller of the RGBA window median filter: sequences push, window scans and output.
// Depends on rwmf_pkg.
module rwmf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_func_i,
  output logic           in_ready_o,
  input  rwmf_pkg::sts_t sts_i,
  output rwmf_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StCheck, StScan, StDrain, StResolve, StEmit
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.push = (in_func_i == rwmf_pkg::FuncPush);
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.win_ready) begin
          cmd_o.setup = 1'b1;
          state_d = StScan;
        end else begin
          state_d = StIdle;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StResolve;
      end
      StResolve: begin
        cmd_o.resolve = 1'b1;
        state_d = sts_i.bit_zero ? StEmit : StScan;
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/rwmf_dpath.sv
// Datapath of the RGBA window median filter: registers, counters, line store and
// bitwise rank selection for four channels. Depends on rwmf_pkg and rwmf_ram.
module rwmf_dpath #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_RADIUS = 7,
  parameter int unsigned STORE_ROWS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rwmf_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [rwmf_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  rwmf_pkg::in_t                        in_data_i,
  input  rwmf_pkg::cmd_t                       cmd_i,
  output rwmf_pkg::sts_t                       sts_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output rwmf_pkg::out_t                       out_data_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SW = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
  localparam int unsigned Depth = STORE_ROWS * MAX_WIDTH;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned RCap = (MAX_RADIUS < (STORE_ROWS - 2) / 2) ?
                                 MAX_RADIUS : (STORE_ROWS - 2) / 2;
  localparam int unsigned HW = rwmf_pkg::RowWidth;
  localparam int unsigned NC = rwmf_pkg::NumChan;

  logic [rwmf_pkg::RadiusWidth-1:0] radius_q;
  logic [rwmf_pkg::FwWidth-1:0]     fw_q;
  logic [rwmf_pkg::FhWidth-1:0]     fh_q;

  logic [CW-1:0] in_col_q, out_col_q;
  logic [HW-1:0] in_row_q, out_row_q;
  logic [SW-1:0] in_slot_q, out_slot_q;

  logic [CW-1:0] x_q, x1_q;
  logic [SW-1:0] slot_q, slot1_q;
  logic [3:0]    ccnt_q, rcnt_q, cols_m1_q, rows_m1_q;
  logic [2:0]    bit_q;
  logic [7:0]    mask_q;
  logic          rd_vld_q;
  logic [7:0]    prefix_q [NC];
  logic [7:0]    k_q [NC];
  logic [7:0]    cnt_q [NC];

  logic          out_valid_q;
  rwmf_pkg::out_t out_q;

  logic [2:0]    eff_r;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [HW:0]   row_sum;
  logic [WW:0]   col_sum;
  logic [HW-1:0] need_row, y1;
  logic [CW-1:0] need_col, x1;
  logic [SW-1:0] y1_slot;
  logic [3:0]    cols_m1, rows_m1;
  logic [8:0]    win_n;
  logic          do_store, last_out, restart;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rdata;
  logic [31:0]   wdata;

  assign eff_r = (int'(radius_q) > int'(RCap)) ? 3'(RCap) : radius_q;
  assign eff_w = (fw_q == '0) ? WW'(1) :
                 (int'(fw_q) > int'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw_q);
  assign eff_h = (fh_q == '0) ? HW'(1) :
                 (int'(fh_q) > int'(rwmf_pkg::HeightLimit)) ?
                 HW'(rwmf_pkg::HeightLimit) : HW'(fh_q);

  assign row_sum = {1'b0, out_row_q} + (HW + 1)'(eff_r);
  assign col_sum = (WW + 1)'(out_col_q) + (WW + 1)'(eff_r);
  assign need_row = (row_sum < (HW + 1)'(eff_h)) ? row_sum[HW-1:0] : eff_h - HW'(1);
  assign need_col = (col_sum < (WW + 1)'(eff_w)) ? CW'(col_sum) : CW'(eff_w - WW'(1));
  assign y1 = (out_row_q >= HW'(eff_r)) ? out_row_q - HW'(eff_r) : '0;
  assign x1 = (CW'(out_col_q) >= CW'(eff_r) && int'(out_col_q) >= int'(eff_r)) ?
              out_col_q - CW'(eff_r) : '0;
  assign y1_slot = (out_row_q < HW'(eff_r)) ? '0 :
                   (int'(out_slot_q) >= int'(eff_r)) ?
                   SW'(int'(out_slot_q) - int'(eff_r)) :
                   SW'(int'(out_slot_q) + int'(STORE_ROWS) - int'(eff_r));
  assign cols_m1 = 4'(need_col - x1);
  assign rows_m1 = 4'(need_row - y1);
  assign win_n = 9'({1'b0, cols_m1} + 5'd1) * 9'({1'b0, rows_m1} + 5'd1);

  assign do_store = cmd_i.push && (in_row_q < eff_h);
  assign last_out = (out_row_q == eff_h - HW'(1)) && (WW'(out_col_q) == eff_w - WW'(1));
  assign restart = cfg_we_i && (cfg_idx_i == rwmf_pkg::RegWindowRadius ||
                                cfg_idx_i == rwmf_pkg::RegFrameWidth ||
                                cfg_idx_i == rwmf_pkg::RegFrameHeight);

  assign waddr = AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
  assign raddr = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(x_q);
  assign wdata = {in_data_i.chan3, in_data_i.chan2, in_data_i.chan1, in_data_i.chan0};

  rwmf_ram #(.Width(32), .Depth(Depth)) u_store (
    .clk_i   (clk_i),
    .we_i    (do_store),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.scan),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sts_o.win_ready = (out_row_q < eff_h) &&
                           ((in_row_q > need_row) ||
                            (in_row_q == need_row && in_col_q > need_col));
  assign sts_o.scan_last = (ccnt_q == '0) && (rcnt_q == '0);
  assign sts_o.bit_zero = (bit_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 3'd1;
      fw_q <= 11'd640;
      fh_q <= 13'd480;
      in_col_q <= '0;
      in_row_q <= '0;
      in_slot_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      out_slot_q <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rwmf_pkg::RegWindowRadius: radius_q <= cfg_data_i[2:0];
          rwmf_pkg::RegFrameWidth:   fw_q <= cfg_data_i[10:0];
          rwmf_pkg::RegFrameHeight:  fh_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (do_store) begin
        if (WW'(in_col_q) + WW'(1) >= eff_w) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + HW'(1);
          in_slot_q <= (in_slot_q == SW'(STORE_ROWS - 1)) ? '0 : in_slot_q + SW'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (last_out) begin
          in_col_q <= '0;
          in_row_q <= '0;
          in_slot_q <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          out_slot_q <= '0;
        end else if (WW'(out_col_q) + WW'(1) >= eff_w) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + HW'(1);
          out_slot_q <= (out_slot_q == SW'(STORE_ROWS - 1)) ? '0 : out_slot_q + SW'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end
      if (restart) begin
        in_col_q <= '0;
        in_row_q <= '0;
        in_slot_q <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
        out_slot_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.med0 <= prefix_q[0];
      out_q.med1 <= prefix_q[1];
      out_q.med2 <= prefix_q[2];
      out_q.med3 <= prefix_q[3];
      out_q.frame_end <= last_out;
    end
    if (cmd_i.setup) begin
      x_q <= x1;
      x1_q <= x1;
      slot_q <= y1_slot;
      slot1_q <= y1_slot;
      cols_m1_q <= cols_m1;
      rows_m1_q <= rows_m1;
      ccnt_q <= cols_m1;
      rcnt_q <= rows_m1;
      bit_q <= 3'd7;
      mask_q <= '0;
    end else if (cmd_i.resolve) begin
      x_q <= x1_q;
      slot_q <= slot1_q;
      ccnt_q <= cols_m1_q;
      rcnt_q <= rows_m1_q;
      bit_q <= bit_q - 3'd1;
      mask_q <= mask_q | (8'd1 << bit_q);
    end else if (cmd_i.scan) begin
      if (ccnt_q == '0) begin
        x_q <= x1_q;
        ccnt_q <= cols_m1_q;
        rcnt_q <= rcnt_q - 4'd1;
        slot_q <= (slot_q == SW'(STORE_ROWS - 1)) ? '0 : slot_q + SW'(1);
      end else begin
        x_q <= x_q + CW'(1);
        ccnt_q <= ccnt_q - 4'd1;
      end
    end
    for (int c = 0; c < NC; c++) begin
      if (cmd_i.setup) begin
        prefix_q[c] <= '0;
        k_q[c] <= 8'((win_n - 9'd1) >> 1);
        cnt_q[c] <= '0;
      end else if (cmd_i.resolve) begin
        cnt_q[c] <= '0;
        if (k_q[c] >= cnt_q[c]) begin
          prefix_q[c] <= prefix_q[c] | (8'd1 << bit_q);
          k_q[c] <= k_q[c] - cnt_q[c];
        end
      end else if (rd_vld_q) begin
        if ((((rdata[8*c +: 8] ^ prefix_q[c]) & mask_q) == '0) && !rdata[8*c + int'(bit_q)]) begin
          cnt_q[c] <= cnt_q[c] + 8'd1;
        end
      end
    end
  end

endmodule

>>> rtl/rgba_window_median_filter.sv
// Top level of the RGBA window median filter.
// Joins rwmf_ctrl and rwmf_dpath; depends on rwmf_pkg.
//
// Pixels enter in raster order on the input channel (valid/ready); func 0 pushes a
// pixel, func 1 is a drain tick that only releases a pending output. Each transfer
// yields at most one output transfer carrying the per-channel lower median of the
// clipped square window around the next output position, with frame_end on the
// last pixel of the frame.
// The window holds at most 225 pixels. For an item that yields an output, the window
// is read from the line store one pixel per cycle, once for each of the eight bits
// of the rank search, all four channels in parallel.
// The output register holds one finished result; the next item is accepted while it
// waits, and its own result waits until the receiver takes the earlier one.
// Reset clears the counters and loads radius 1, width 640, height 480. The line store
// needs no clearing. A radius, width or height write restarts the frame.
module rgba_window_median_filter #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_RADIUS = 7,
  parameter int unsigned STORE_ROWS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rwmf_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [rwmf_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rwmf_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rwmf_pkg::out_t                    out_data_o
);

  rwmf_pkg::cmd_t cmd;
  rwmf_pkg::sts_t sts;

  rwmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rwmf_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS),
    .STORE_ROWS (STORE_ROWS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/rwmf_checker.sv
// Port-level checks for the RGBA window median filter, bound to the top level.
// Depends on rwmf_pkg.
module rwmf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rwmf_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("output appeared without processing");

endmodule

bind rgba_window_median_filter rwmf_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> sim/tb.sv
// Testbench for the RGBA window median filter.
// Drives pixel and drain transfers, predicts every median in a behavioral model, and checks
// each output transfer. Depends on rwmf_pkg and rgba_window_median_filter.
`timescale 1ns / 1ps

module tb;

  localparam logic [rwmf_pkg::CfgIdxWidth-1:0] RegUnused = 2'd3;
  localparam int unsigned DrainPause = 2000;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned RandomItems = 1800;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [rwmf_pkg::CfgIdxWidth-1:0]  cfg_idx_i = '0;
  logic [rwmf_pkg::CfgDataWidth-1:0] cfg_data_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  rwmf_pkg::in_t                     in_data_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  rwmf_pkg::out_t                    out_data_o;

  rgba_window_median_filter u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Behavioral copy of the filter state.
  logic [31:0]    line_mem [16][1024];
  int unsigned    m_radius, m_width, m_height;
  int unsigned    m_in_col, m_in_row, m_out_col, m_out_row;
  bit             frame_done;
  rwmf_pkg::out_t median_q[$];
  int unsigned    errors = 0;
  int unsigned    items_sent = 0;
  int unsigned    send_idle = 0;
  int unsigned    recv_idle = 0;
  int unsigned    stall_cnt = 0;

  task automatic predict_item(input rwmf_pkg::in_t item);
    int unsigned w, h, r, need_row, need_col, x1, y1, n, cum, k;
    int unsigned hist[256];
    logic [7:0] med[4];
    rwmf_pkg::out_t res;
    w = (m_width == 0) ? 1 : ((m_width > 1024) ? 1024 : m_width);
    h = (m_height == 0) ? 1 :
        ((m_height > rwmf_pkg::HeightLimit) ? rwmf_pkg::HeightLimit : m_height);
    r = (m_radius > 7) ? 7 : m_radius;
    if (item.func == rwmf_pkg::FuncPush && m_in_row < h) begin
      line_mem[m_in_row % 16][m_in_col] = {item.chan3, item.chan2, item.chan1, item.chan0};
      m_in_col++;
      if (m_in_col >= w) begin
        m_in_col = 0;
        m_in_row++;
      end
    end
    if (m_out_row >= h) return;
    need_row = (m_out_row + r < h) ? m_out_row + r : h - 1;
    need_col = (m_out_col + r < w) ? m_out_col + r : w - 1;
    if (!(m_in_row > need_row || (m_in_row == need_row && m_in_col > need_col))) return;
    y1 = (m_out_row >= r) ? m_out_row - r : 0;
    x1 = (m_out_col >= r) ? m_out_col - r : 0;
    n = (need_row - y1 + 1) * (need_col - x1 + 1);
    for (int c = 0; c < 4; c++) begin
      for (int v = 0; v < 256; v++) hist[v] = 0;
      for (int y = y1; y <= need_row; y++)
        for (int x = x1; x <= need_col; x++)
          hist[line_mem[y % 16][x][8*c +: 8]]++;
      cum = 0;
      k = 0;
      while (cum + hist[k] <= (n - 1) / 2) begin
        cum += hist[k];
        k++;
      end
      med[c] = k[7:0];
    end
    res.med0 = med[0];
    res.med1 = med[1];
    res.med2 = med[2];
    res.med3 = med[3];
    res.frame_end = (m_out_row == h - 1 && m_out_col == w - 1);
    median_q.push_back(res);
    m_out_col++;
    if (m_out_col >= w) begin
      m_out_col = 0;
      m_out_row++;
    end
    if (res.frame_end) begin
      {m_in_col, m_in_row, m_out_col, m_out_row} = '0;
      frame_done = 1'b1;
    end
  endtask

  task automatic send_item(input logic func, input logic [31:0] px);
    rwmf_pkg::in_t item;
    int unsigned gap;
    item = {func, px[7:0], px[15:8], px[23:16], px[31:24]};
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(item);
    items_sent++;
  endtask

  // Registers change only once the block has gone quiet.
  task automatic write_regs(input logic [rwmf_pkg::CfgIdxWidth-1:0] idx[$],
                            input logic [rwmf_pkg::CfgDataWidth-1:0] val[$]);
    in_valid_i <= 1'b0;
    wait (median_q.size() == 0);
    repeat (DrainPause) @(posedge clk_i);
    foreach (idx[i]) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      case (idx[i])
        rwmf_pkg::RegWindowRadius: m_radius = val[i] & 13'h7;
        rwmf_pkg::RegFrameWidth:   m_width = val[i] & 13'h7ff;
        rwmf_pkg::RegFrameHeight:  m_height = val[i];
        default: ;
      endcase
      if (idx[i] != RegUnused) {m_in_col, m_in_row, m_out_col, m_out_row} = '0;
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_frame(input int unsigned r, input int unsigned w, input int unsigned h);
    write_regs({rwmf_pkg::RegWindowRadius, rwmf_pkg::RegFrameWidth, rwmf_pkg::RegFrameHeight},
               {r[rwmf_pkg::CfgDataWidth-1:0], w[rwmf_pkg::CfgDataWidth-1:0],
                h[rwmf_pkg::CfgDataWidth-1:0]});
  endtask

  // Pushes a frame, then drains to its last output; optional noise mixes in the other kind.
  task automatic run_frame(input int unsigned npix, input int unsigned noise);
    frame_done = 1'b0;
    for (int i = 0; i < npix; ) begin
      if ($urandom_range(99) < noise) begin
        send_item(rwmf_pkg::FuncDrain, $urandom);
      end else begin
        send_item(rwmf_pkg::FuncPush, $urandom);
        i++;
      end
    end
    while (!frame_done)
      send_item(($urandom_range(99) < noise) ? rwmf_pkg::FuncPush : rwmf_pkg::FuncDrain,
                $urandom);
  endtask

  task automatic test_reset_values();
    send_item(rwmf_pkg::FuncDrain, 32'h0);
    send_item(rwmf_pkg::FuncPush, 32'hffffffff);
    send_item(rwmf_pkg::FuncPush, 32'h00000000);
    send_item(rwmf_pkg::FuncDrain, 32'h0);
    write_regs({RegUnused}, {13'h1fff});
    send_item(rwmf_pkg::FuncPush, 32'h5a5a5a5a);
  endtask

  task automatic test_saturation();
    set_frame(7, 0, 3);
    frame_done = 1'b0;
    send_item(rwmf_pkg::FuncPush, 32'h00000000);
    send_item(rwmf_pkg::FuncPush, 32'hffffffff);
    send_item(rwmf_pkg::FuncPush, 32'h00ff00ff);
    send_item(rwmf_pkg::FuncPush, 32'hff00ff00);
    send_item(rwmf_pkg::FuncDrain, 32'h0);
    set_frame(0, 2047, 1);
    repeat (4) send_item(rwmf_pkg::FuncPush, $urandom);
    set_frame(2, 2, 8191);
    repeat (5) send_item(rwmf_pkg::FuncPush, $urandom);
  endtask

  task automatic test_small_frames();
    set_frame(1, 2, 2);
    run_frame(4, 0);
    set_frame(7, 3, 3);
    run_frame(9, 20);
  endtask

  task automatic test_random();
    int unsigned r, w, h, limit;
    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 35 : ((mode == 1) ? 55 : 0);
      recv_idle = (mode == 0) ? 55 : ((mode == 1) ? 35 : 0);
      limit = items_sent + RandomItems / 3;
      while (items_sent < limit) begin
        r = ($urandom_range(9) < 7) ? $urandom_range(2) : $urandom_range(7, 3);
        w = (r >= 4) ? $urandom_range(6, 1) : $urandom_range(14, 1);
        h = (r >= 4) ? $urandom_range(6, 1) : $urandom_range(10, 1);
        set_frame(r, w, h);
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(w * h)) send_item(1'($urandom_range(1)), $urandom);
        end else begin
          run_frame(w * h, $urandom_range(1) ? 10 : 0);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
    if (out_valid_o && out_ready_i) begin
      if (median_q.size() == 0) begin
        $error("unexpected output transfer");
        errors++;
      end else begin
        rwmf_pkg::out_t e;
        e = median_q.pop_front();
        if (out_data_o.med0 !== e.med0) begin
          $error("med0 expected %0d actual %0d", e.med0, out_data_o.med0);
          errors++;
        end
        if (out_data_o.med1 !== e.med1) begin
          $error("med1 expected %0d actual %0d", e.med1, out_data_o.med1);
          errors++;
        end
        if (out_data_o.med2 !== e.med2) begin
          $error("med2 expected %0d actual %0d", e.med2, out_data_o.med2);
          errors++;
        end
        if (out_data_o.med3 !== e.med3) begin
          $error("med3 expected %0d actual %0d", e.med3, out_data_o.med3);
          errors++;
        end
        if (out_data_o.frame_end !== e.frame_end) begin
          $error("frame_end expected %0d actual %0d", e.frame_end, out_data_o.frame_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    m_radius = 1;
    m_width = 640;
    m_height = 480;
    {m_in_col, m_in_row, m_out_col, m_out_row} = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_saturation();
    test_small_frames();
    test_random();
    in_valid_i <= 1'b0;
    wait (median_q.size() == 0);
    repeat (DrainPause) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/rwmf_pkg.sv
rtl/rwmf_ram.sv
rtl/rwmf_ctrl.sv
rtl/rwmf_dpath.sv
rtl/rgba_window_median_filter.sv
rtl/rwmf_checker.sv
sim/tb.sv
